// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the Playfair cipher core.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/pfc_pkg.sv
// Types, codes and key-square helper functions of the Playfair cipher core.
// No dependencies; used by the front end, the back end and the top level of the block.
`default_nettype none
package pfc_pkg;

  localparam int COUNT_W     = 5;
  localparam int GAP_CAP_MAX = 18;
  localparam int SQUARE_W    = 125;

  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_Z     = 8'd90;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [4:0] CODE_I     = 5'd8;
  localparam logic [4:0] CODE_J     = 5'd9;
  localparam logic [4:0] CODE_Z     = 5'd25;
  localparam logic [2:0] GROUP_LAST = 3'd4;

  localparam logic [1:0] FMT_AS_IS   = 2'd0;
  localparam logic [1:0] FMT_LETTERS = 2'd1;
  localparam logic [1:0] FMT_GROUPS  = 2'd2;

  localparam logic [2:0] REG_SQUARE_LOW  = 3'd0;
  localparam logic [2:0] REG_SQUARE_MID  = 3'd1;
  localparam logic [2:0] REG_SQUARE_LAST = 3'd2;
  localparam logic [2:0] REG_DECRYPT     = 3'd3;
  localparam logic [2:0] REG_FORMAT      = 3'd4;

  typedef enum logic {CMD_TEXT = 1'b0, CMD_FLUSH = 1'b1} cmd_t;

  typedef enum logic [1:0] {JOB_NONE, JOB_PASS, JOB_PAIR, JOB_FILLED} job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    logic [7:0]           ch;    // passed byte, or first letter code in [4:0]
    logic [4:0]           b;     // second letter code
    logic [COUNT_W-1:0]   gaps;
    logic                 ovf;
    logic                 clr;   // clear group count when done
  } job_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic [SQUARE_W-1:0] square;
    logic                decrypt;
    logic [1:0]          fmt;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FIRST, B_SECOND, B_GAP_RD, B_GAP_EM, B_SPACE, B_DONE
  } back_state_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  function automatic logic [4:0] find_cell(input logic [SQUARE_W-1:0] sq,
                                           input logic [4:0] l);
    logic [4:0] res;
    res = '0;
    for (int k = 24; k >= 0; k--) begin
      if (sq[5*k +: 5] == l) res = 5'(k);
    end
    return res;
  endfunction

  function automatic pos_t cell_pos(input logic [4:0] n);
    pos_t p;
    p = '0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (n == 5'(r * 5 + c)) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

  function automatic logic [4:0] cell_code(input logic [SQUARE_W-1:0] sq,
                                           input logic [4:0] n);
    logic [4:0] code;
    code = '0;
    for (int k = 0; k < 25; k++) begin
      if (n == 5'(k)) code = sq[5*k +: 5];
    end
    return code;
  endfunction

  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else     r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/pfc_fifo.sv
// Small register queue with fall-through head, between front and back ends.
// No dependencies.
`default_nettype none
module pfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (rd_en) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (wr_en && !rd_en)      count <= count + CW'(1);
      else if (!wr_en && rd_en) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

endmodule
`default_nettype wire

// File: hw/rtl/pfc_front.sv
// Front end: accepts items, pairs letters, buffers gap bytes and queues jobs.
// Depends on pfc_pkg.
`default_nettype none
module pfc_front #(
  parameter int GAP_CAP = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic [7:0]                   in_char,
  input  wire logic                         q_full,
  input  wire logic                         gap_release,
  output logic                              job_push,
  output pfc_pkg::job_t                     job,
  output logic                              gap_wr_en,
  output logic      [$clog2(GAP_CAP)-1:0]   gap_wr_addr,
  output logic      [7:0]                   gap_wr_data
);

  localparam int AW = $clog2(GAP_CAP);
  localparam int CW = $clog2(GAP_CAP + 1);

  logic [4:0]    pending_letter, pending_letter_next;
  logic          pending_valid, pending_valid_next;
  logic [CW-1:0] gap_count, gap_count_next;
  logic          overflow_seen, overflow_seen_next;
  logic          gap_busy, gap_busy_next;
  logic          accept;
  logic [4:0]    code;

  assign in_ready    = !gap_busy && !q_full;
  assign accept      = in_valid && in_ready;
  assign gap_wr_addr = gap_count[AW-1:0];
  assign gap_wr_data = in_char;

  always_comb begin
    code = 5'(in_char - pfc_pkg::CHAR_A);
    if (code == pfc_pkg::CODE_J) code = pfc_pkg::CODE_I;
  end

  always_comb begin
    pending_letter_next = pending_letter;
    pending_valid_next  = pending_valid;
    gap_count_next      = gap_count;
    overflow_seen_next  = overflow_seen;
    job_push            = 1'b0;
    gap_wr_en           = 1'b0;
    job.kind            = pfc_pkg::JOB_NONE;
    job.ch              = {3'b000, pending_letter};
    job.b               = pfc_pkg::CODE_Z;
    job.gaps            = pfc_pkg::COUNT_W'(gap_count);
    job.ovf             = overflow_seen;
    job.clr             = 1'b0;
    if (accept) begin
      if (in_cmd == pfc_pkg::CMD_FLUSH) begin
        job_push            = 1'b1;
        job.kind            = pending_valid ? pfc_pkg::JOB_FILLED : pfc_pkg::JOB_NONE;
        job.clr             = 1'b1;
        pending_valid_next  = 1'b0;
        pending_letter_next = '0;
        gap_count_next      = '0;
        overflow_seen_next  = 1'b0;
      end else if (pfc_pkg::is_letter(in_char)) begin
        if (!pending_valid) begin
          pending_letter_next = code;
          pending_valid_next  = 1'b1;
        end else if (code == pending_letter) begin
          job_push           = 1'b1;
          job.kind           = pfc_pkg::JOB_FILLED;
          gap_count_next     = '0;
          overflow_seen_next = 1'b0;
        end else begin
          job_push            = 1'b1;
          job.kind            = pfc_pkg::JOB_PAIR;
          job.b               = code;
          pending_valid_next  = 1'b0;
          pending_letter_next = '0;
          gap_count_next      = '0;
          overflow_seen_next  = 1'b0;
        end
      end else if (!pending_valid) begin
        job_push = 1'b1;
        job.kind = pfc_pkg::JOB_PASS;
        job.ch   = in_char;
      end else if (gap_count < CW'(GAP_CAP)) begin
        gap_wr_en      = 1'b1;
        gap_count_next = gap_count + CW'(1);
      end else begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_comb begin
    gap_busy_next = gap_busy;
    if (job_push && job.gaps != '0) gap_busy_next = 1'b1;
    else if (gap_release)           gap_busy_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_letter <= '0;
      pending_valid  <= 1'b0;
      gap_count      <= '0;
      overflow_seen  <= 1'b0;
      gap_busy       <= 1'b0;
    end else begin
      pending_letter <= pending_letter_next;
      pending_valid  <= pending_valid_next;
      gap_count      <= gap_count_next;
      overflow_seen  <= overflow_seen_next;
      gap_busy       <= gap_busy_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pfc_back.sv
// Back end: ciphers queued pairs, drains gap bytes, formats and registers results.
// Depends on pfc_pkg; reads the gap RAM instantiated at the top level.
`default_nettype none
module pfc_back #(
  parameter int AW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfc_pkg::cfg_t     cfg,
  input  wire logic              job_valid,
  input  wire pfc_pkg::job_t     job_in,
  output logic                   job_pop,
  output logic                   gap_rd_en,
  output logic      [AW-1:0]     gap_rd_addr,
  input  wire logic [7:0]        gap_rd_data,
  output logic                   gap_release,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_char,
  output logic                   out_last,
  output logic                   out_ovf
);

  pfc_pkg::back_state_t state, state_next, ret_state, ret_state_next;
  pfc_pkg::job_t job;
  pfc_pkg::pos_t pos_a, pos_b;
  logic [2:0]                   group_count;
  logic [pfc_pkg::COUNT_W-1:0]  gidx;
  logic [7:0]                   hold_char;
  logic                         hold_valid;

  logic       out_free, can_put, filtering, keep, put, advance, finish, group_wrap;
  logic       load, last_gap;
  logic [7:0] elem_char, put_char, x_char, y_char;
  logic [4:0] na, nb;
  logic [2:0] sa_r, sa_c, sb_r, sb_c;

  assign out_free    = !out_valid || out_ready;
  assign can_put     = !hold_valid || out_free;
  assign filtering   = (cfg.fmt == pfc_pkg::FMT_LETTERS) || (cfg.fmt == pfc_pkg::FMT_GROUPS);
  assign gap_rd_addr = gidx[AW-1:0];
  assign load        = (state == pfc_pkg::B_IDLE) && job_valid;
  assign last_gap    = (pfc_pkg::COUNT_W'(gidx + 1'b1) == job.gaps);

  // Playfair substitution from the registered cell positions
  always_comb begin
    sa_r = pfc_pkg::wrap_step(pos_a.row, cfg.decrypt);
    sa_c = pfc_pkg::wrap_step(pos_a.col, cfg.decrypt);
    sb_r = pfc_pkg::wrap_step(pos_b.row, cfg.decrypt);
    sb_c = pfc_pkg::wrap_step(pos_b.col, cfg.decrypt);
    if (pos_a.row == pos_b.row) begin
      na = pfc_pkg::cell_index(pos_a.row, sa_c);
      nb = pfc_pkg::cell_index(pos_b.row, sb_c);
    end else if (pos_a.col == pos_b.col) begin
      na = pfc_pkg::cell_index(sa_r, pos_a.col);
      nb = pfc_pkg::cell_index(sb_r, pos_b.col);
    end else begin
      na = pfc_pkg::cell_index(pos_a.row, pos_b.col);
      nb = pfc_pkg::cell_index(pos_b.row, pos_a.col);
    end
    x_char = pfc_pkg::CHAR_A + {3'b000, pfc_pkg::cell_code(cfg.square, na)};
    y_char = pfc_pkg::CHAR_A + {3'b000, pfc_pkg::cell_code(cfg.square, nb)};
  end

  // outputs of the sequencer
  always_comb begin
    job_pop     = 1'b0;
    gap_rd_en   = 1'b0;
    gap_release = 1'b0;
    put         = 1'b0;
    advance     = 1'b0;
    finish      = 1'b0;
    elem_char   = x_char;
    case (state)
      pfc_pkg::B_FIRST:  elem_char = (job.kind == pfc_pkg::JOB_PASS) ? job.ch : x_char;
      pfc_pkg::B_SECOND: elem_char = y_char;
      pfc_pkg::B_GAP_EM: elem_char = gap_rd_data;
      pfc_pkg::B_SPACE:  elem_char = pfc_pkg::CHAR_SPACE;
      default:           elem_char = x_char;
    endcase
    keep     = !filtering || pfc_pkg::is_letter(elem_char);
    put_char = elem_char;
    case (state)
      pfc_pkg::B_IDLE: job_pop = job_valid;
      pfc_pkg::B_FIRST, pfc_pkg::B_SECOND, pfc_pkg::B_GAP_EM: begin
        put     = keep && can_put;
        advance = !keep || can_put;
      end
      pfc_pkg::B_GAP_RD: gap_rd_en = 1'b1;
      pfc_pkg::B_SPACE: begin
        put     = can_put;
        advance = can_put;
      end
      pfc_pkg::B_DONE: begin
        finish      = !hold_valid || out_free;
        gap_release = finish && (job.gaps != '0);
      end
      default: ;
    endcase
    group_wrap = put && (state != pfc_pkg::B_SPACE) && (cfg.fmt == pfc_pkg::FMT_GROUPS) &&
                 (group_count == pfc_pkg::GROUP_LAST);
  end

  // next state
  always_comb begin
    pfc_pkg::back_state_t after;
    state_next     = state;
    ret_state_next = ret_state;
    after          = pfc_pkg::B_DONE;
    case (state)
      pfc_pkg::B_FIRST: begin
        if (job.kind == pfc_pkg::JOB_PASS)      after = pfc_pkg::B_DONE;
        else if (job.kind == pfc_pkg::JOB_PAIR && job.gaps != '0)
                                                after = pfc_pkg::B_GAP_RD;
        else                                    after = pfc_pkg::B_SECOND;
      end
      pfc_pkg::B_SECOND: begin
        after = (job.kind == pfc_pkg::JOB_FILLED && job.gaps != '0) ?
                pfc_pkg::B_GAP_RD : pfc_pkg::B_DONE;
      end
      pfc_pkg::B_GAP_EM: begin
        if (!last_gap)                       after = pfc_pkg::B_GAP_RD;
        else if (job.kind == pfc_pkg::JOB_PAIR) after = pfc_pkg::B_SECOND;
        else                                 after = pfc_pkg::B_DONE;
      end
      default: after = pfc_pkg::B_DONE;
    endcase
    case (state)
      pfc_pkg::B_IDLE: begin
        if (job_valid) state_next = (job_in.kind == pfc_pkg::JOB_NONE) ?
                                    pfc_pkg::B_DONE : pfc_pkg::B_FIRST;
      end
      pfc_pkg::B_FIRST, pfc_pkg::B_SECOND, pfc_pkg::B_GAP_EM: begin
        if (advance) begin
          if (group_wrap) begin
            state_next     = pfc_pkg::B_SPACE;
            ret_state_next = after;
          end else begin
            state_next = after;
          end
        end
      end
      pfc_pkg::B_GAP_RD: state_next = pfc_pkg::B_GAP_EM;
      pfc_pkg::B_SPACE:  if (advance) state_next = ret_state;
      pfc_pkg::B_DONE:   if (finish) state_next = pfc_pkg::B_IDLE;
      default:           state_next = pfc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pfc_pkg::B_IDLE;
      ret_state   <= pfc_pkg::B_DONE;
      group_count <= '0;
      hold_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      if (finish && job.clr)   group_count <= '0;
      else if (group_wrap)     group_count <= '0;
      else if (put && state != pfc_pkg::B_SPACE && cfg.fmt == pfc_pkg::FMT_GROUPS)
                               group_count <= group_count + 3'd1;
      if (put && hold_valid)         out_valid <= 1'b1;
      else if (finish && hold_valid) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
      if (put)                       hold_valid <= 1'b1;
      else if (finish && hold_valid) hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job   <= job_in;
      pos_a <= pfc_pkg::cell_pos(pfc_pkg::find_cell(cfg.square, job_in.ch[4:0]));
      pos_b <= pfc_pkg::cell_pos(pfc_pkg::find_cell(cfg.square, job_in.b));
      gidx  <= '0;
    end else if (state == pfc_pkg::B_GAP_EM && advance) begin
      gidx <= gidx + 1'b1;
    end
    if (put) begin
      hold_char <= put_char;
      if (hold_valid) begin
        out_char <= hold_char;
        out_last <= 1'b0;
        out_ovf  <= job.ovf;
      end
    end else if (finish && hold_valid) begin
      out_char <= hold_char;
      out_last <= 1'b1;
      out_ovf  <= job.ovf;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/playfair_digram_stream_cipher_core.sv
// Playfair digram stream cipher core: config registers, front end, job queue,
// gap RAM and back end. Depends on pfc_pkg, pfc_ram, pfc_fifo, pfc_front, pfc_back.
//
// Byte-stream Playfair encrypt/decrypt over a 5x5 key square loaded through the
// config port (write it only while the core is idle). The front end takes one
// item per cycle while the job queue has room and no job that holds gap bytes
// is queued or draining. Items that give results become jobs for the back end,
// which emits each cipher letter, passed byte or group space in turn and reads
// each buffered gap byte from the registered gap RAM before emitting it; a
// stalled output holds it up. While a job that holds gap bytes is queued or
// draining, s_tready stays low. The last result of an item carries m_tlast;
// m_tuser flags a dropped gap byte before that pair.
`default_nettype none
`include "assert_macros.svh"
module playfair_digram_stream_cipher_core #(
  parameter int GAP_DEPTH   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [7:0] out_char
  output logic             m_tlast,
  output logic             m_tuser,   // [0] gap_overflow
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [59:0] cfg_data
);

  localparam int GAP_CAP = (GAP_DEPTH < pfc_pkg::GAP_CAP_MAX) ? GAP_DEPTH :
                           pfc_pkg::GAP_CAP_MAX;
  localparam int GAP_AW  = $clog2(GAP_CAP);
  localparam int JOB_W   = $bits(pfc_pkg::job_t);

  logic [59:0] square_low;
  logic [59:0] square_mid;
  logic [4:0]  square_last;
  logic        decrypt_mode;
  logic [1:0]  output_format;

  pfc_pkg::cfg_t cfg;
  pfc_pkg::job_t job_new;
  logic [JOB_W-1:0] job_head;
  logic              job_push, job_pop, fifo_full, fifo_empty, gap_release;
  logic              gap_wr_en, gap_rd_en;
  logic [GAP_AW-1:0] gap_wr_addr, gap_rd_addr;
  logic [7:0]        gap_wr_data, gap_rd_data;

  assign cfg_ready  = 1'b1;
  assign cfg.square = {square_last, square_mid, square_low};
  assign cfg.decrypt = decrypt_mode;
  assign cfg.fmt    = output_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_low    <= '0;
      square_mid    <= '0;
      square_last   <= '0;
      decrypt_mode  <= 1'b0;
      output_format <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfc_pkg::REG_SQUARE_LOW:  square_low    <= cfg_data;
        pfc_pkg::REG_SQUARE_MID:  square_mid    <= cfg_data;
        pfc_pkg::REG_SQUARE_LAST: square_last   <= cfg_data[4:0];
        pfc_pkg::REG_DECRYPT:     decrypt_mode  <= cfg_data[0];
        pfc_pkg::REG_FORMAT:      output_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  pfc_front #(.GAP_CAP(GAP_CAP)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_char     (s_tdata),
    .q_full      (fifo_full),
    .gap_release (gap_release),
    .job_push    (job_push),
    .job         (job_new),
    .gap_wr_en   (gap_wr_en),
    .gap_wr_addr (gap_wr_addr),
    .gap_wr_data (gap_wr_data)
  );

  pfc_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_new),
    .rd_en   (job_pop),
    .rd_data (job_head),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  pfc_ram #(.WIDTH(8), .DEPTH(GAP_CAP)) u_gap_ram (
    .clk     (clk),
    .wr_en   (gap_wr_en),
    .wr_addr (gap_wr_addr),
    .wr_data (gap_wr_data),
    .rd_en   (gap_rd_en),
    .rd_addr (gap_rd_addr),
    .rd_data (gap_rd_data)
  );

  pfc_back #(.AW(GAP_AW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job_valid   (!fifo_empty),
    .job_in      (pfc_pkg::job_t'(job_head)),
    .job_pop     (job_pop),
    .gap_rd_en   (gap_rd_en),
    .gap_rd_addr (gap_rd_addr),
    .gap_rd_data (gap_rd_data),
    .gap_release (gap_release),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_char    (m_tdata),
    .out_last    (m_tlast),
    .out_ovf     (m_tuser)
  );

  `ASSERT_ALWAYS(a_gap_rw_apart, clk, rst, !(gap_wr_en && gap_rd_en))
  `ASSERT_ALWAYS(a_no_push_full, clk, rst, !(job_push && fifo_full))
  `ASSERT_NEXT(a_push_lands, clk, rst, job_push && !job_pop, !fifo_empty)

endmodule
`default_nettype wire
